// ===== hdl/psc_pkg.sv =====
package psc_pkg;

	localparam int N_CALIB   = 6;
	localparam int IDX_W     = 3;

	// Register indexes of the calibration port.
	localparam logic [IDX_W-1:0] REG_T1_T2 = 3'd0;
	localparam logic [IDX_W-1:0] REG_T3_P1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_P2_P3 = 3'd2;
	localparam logic [IDX_W-1:0] REG_P4_P5 = 3'd3;
	localparam logic [IDX_W-1:0] REG_P6_P7 = 3'd4;
	localparam logic [IDX_W-1:0] REG_P8_P9 = 3'd5;

	// Divider: one sign stage, one stage per quotient bit, one negate stage.
	localparam int DIV_BITS = 64;
	localparam int DIV_LAT  = DIV_BITS + 2;

	typedef struct packed {
		logic [15:0] tsat;
		logic [31:0] tfine;
	} temp_res_t;

endpackage

// ===== hdl/psc_delay.sv =====
module psc_delay import psc_pkg::*; #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				pipe_q[i] <= pipe_q[i-1];
			end
		end
	end

	assign q = pipe_q[N-1];

endmodule

// ===== hdl/psc_mul64.sv =====
module psc_mul64 import psc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	// Low 64 bits of a 64x64 product from three 32x32 partial products.
	logic [63:0] ll;
	logic [63:0] c_lh;
	logic [63:0] c_hl;
	logic [63:0] ll_s1;
	logic [31:0] cr_s1;
	logic [63:0] p_s2;

	assign ll   = a[31:0] * b[31:0];
	assign c_lh = a[31:0] * b[63:32];
	assign c_hl = a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ll;
			cr_s1 <= c_lh[31:0] + c_hl[31:0];
			p_s2  <= ll_s1 + {cr_s1, 32'h0};
		end
	end

	assign p = p_s2;

endmodule

// ===== hdl/psc_div.sv =====
module psc_div import psc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic [63:0] quo
);

	// Signed division truncating toward zero, restoring, one bit per stage.
	logic [63:0] rem_s [DIV_BITS+1];
	logic [63:0] n_s   [DIV_BITS+1];
	logic [63:0] d_s   [DIV_BITS+1];
	logic        neg_s [DIV_BITS+1];
	logic [63:0] quo_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			n_s[0]   <= num[63] ? (64'd0 - num) : num;
			d_s[0]   <= den[63] ? (64'd0 - den) : den;
			neg_s[0] <= num[63] ^ den[63];
		end
	end

	for (genvar k = 1; k <= DIV_BITS; k++) begin : g_bit
		logic [64:0] trial;
		assign trial = {rem_s[k-1], n_s[k-1][63]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {1'b0, d_s[k-1]}) begin
					rem_s[k] <= 64'(trial - {1'b0, d_s[k-1]});
					n_s[k]   <= {n_s[k-1][62:0], 1'b1};
				end else begin
					rem_s[k] <= trial[63:0];
					n_s[k]   <= {n_s[k-1][62:0], 1'b0};
				end
				d_s[k]   <= d_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= neg_s[DIV_BITS] ? (64'd0 - n_s[DIV_BITS]) : n_s[DIV_BITS];
		end
	end

	assign quo = quo_q;

endmodule

// ===== hdl/pressure_sensor_compensation.sv =====
// Compensates one raw temperature/pressure request per clock while in_stall is
// low, with the integer formulas of this sensor class, using six calibration
// registers written through the wr_en/wr_index/wr_data port. The user must write
// them only while no request is in flight; the block does not enforce this. The
// path is mostly the 64-stage quotient pipeline of the pressure division, the rest
// is the registered 64-bit multipliers and the temperature stages. The whole
// pipeline holds while a finished result is stalled at the output and advances
// every cycle otherwise, so gaps between requests are kept as they are. When the
// pressure divisor is zero, pressure_q24_8 is 0 and pressure_valid is low.
module pressure_sensor_compensation import psc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] temperature_centi,
	output logic signed [31:0] fine_temperature,
	output logic [31:0]        pressure_q24_8,
	output logic               pressure_valid,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [31:0]        wr_data
);

	localparam int N_STAGE = 89;

	logic [31:0] calib_q [N_CALIB];
	logic [N_STAGE:1] vld_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_CALIB; i++) begin
				calib_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_T1_T2: calib_q[REG_T1_T2] <= wr_data;
				REG_T3_P1: calib_q[REG_T3_P1] <= wr_data;
				REG_P2_P3: calib_q[REG_P2_P3] <= wr_data;
				REG_P4_P5: calib_q[REG_P4_P5] <= wr_data;
				REG_P6_P7: calib_q[REG_P6_P7] <= wr_data;
				REG_P8_P9: calib_q[REG_P8_P9] <= wr_data;
				default: ;
			endcase
		end
	end

	assign en       = !vld_q[N_STAGE] || !out_stall;
	assign in_stall = vld_q[N_STAGE] && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N_STAGE-1:1], in_valid};
		end
	end

	// Calibration words; the user must change them only while the pipeline is empty, which the block does not enforce.
	logic [31:0] t1, t2, t3;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = {16'h0, calib_q[REG_T1_T2][15:0]};
	assign t2 = {{16{calib_q[REG_T1_T2][31]}}, calib_q[REG_T1_T2][31:16]};
	assign t3 = {{16{calib_q[REG_T3_P1][15]}}, calib_q[REG_T3_P1][15:0]};
	assign p1 = {48'h0, calib_q[REG_T3_P1][31:16]};
	assign p2 = {{48{calib_q[REG_P2_P3][15]}}, calib_q[REG_P2_P3][15:0]};
	assign p3 = {{48{calib_q[REG_P2_P3][31]}}, calib_q[REG_P2_P3][31:16]};
	assign p4 = {{48{calib_q[REG_P4_P5][15]}}, calib_q[REG_P4_P5][15:0]};
	assign p5 = {{48{calib_q[REG_P4_P5][31]}}, calib_q[REG_P4_P5][31:16]};
	assign p6 = {{48{calib_q[REG_P6_P7][15]}}, calib_q[REG_P6_P7][15:0]};
	assign p7 = {{48{calib_q[REG_P6_P7][31]}}, calib_q[REG_P6_P7][31:16]};
	assign p8 = {{48{calib_q[REG_P8_P9][15]}}, calib_q[REG_P8_P9][15:0]};
	assign p9 = {{48{calib_q[REG_P8_P9][31]}}, calib_q[REG_P8_P9][31:16]};

	// Temperature, 32-bit wrapping arithmetic.
	logic [31:0] a_s1, b_s1, m1_s2, bb_s2, v1t_s3, x_s3, v1t_s4, m2_s4, tfine_s5;
	logic [63:0] m1_w, bb_w, m2_w;
	logic [35:0] tw, tm, ts;
	logic [15:0] tsat_w, tsat_s6;
	logic [31:0] tfine_s6;
	logic [63:0] pv1_s6;

	assign m1_w = a_s1 * t2;
	assign bb_w = b_s1 * b_s1;
	assign m2_w = x_s3 * t3;

	assign tw = {{4{tfine_s5[31]}}, tfine_s5};
	assign tm = (tw << 2) + tw + 36'd128;
	assign ts = $signed(tm) >>> 8;

	always_comb begin
		if ($signed(ts) > 36'sd32767) begin
			tsat_w = 16'h7FFF;
		end else if ($signed(ts) < -36'sd32768) begin
			tsat_w = 16'h8000;
		end else begin
			tsat_w = ts[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= {15'h0, raw_temperature[19:3]} - {t1[30:0], 1'b0};
			b_s1     <= {16'h0, raw_temperature[19:4]} - t1;
			m1_s2    <= m1_w[31:0];
			bb_s2    <= bb_w[31:0];
			v1t_s3   <= $signed(m1_s2) >>> 11;
			x_s3     <= $signed(bb_s2) >>> 12;
			v1t_s4   <= v1t_s3;
			m2_s4    <= m2_w[31:0];
			tfine_s5 <= v1t_s4 + 32'($signed(m2_s4) >>> 14);
			tsat_s6  <= tsat_w;
			tfine_s6 <= tfine_s5;
			pv1_s6   <= {{32{tfine_s5[31]}}, tfine_s5} - 64'd128000;
		end
	end

	// Pressure divisor and dividend, 64-bit wrapping arithmetic.
	logic [63:0] sq_s8, v1p5_s8, v1p2_s8, sqp6_s10, sqp3_s10, v1p5_s10, v1p2_s10;
	logic [63:0] v2_s11, v1b_s11, v2_s14, y_s12, z_s14, dv_s15, pp_s15, dv_s17, nm_s17;
	logic [19:0] adcp_s14;

	psc_mul64 u_sq   (.clk, .en, .a(pv1_s6), .b(pv1_s6), .p(sq_s8));
	psc_mul64 u_v1p5 (.clk, .en, .a(pv1_s6), .b(p5), .p(v1p5_s8));
	psc_mul64 u_v1p2 (.clk, .en, .a(pv1_s6), .b(p2), .p(v1p2_s8));
	psc_mul64 u_sqp6 (.clk, .en, .a(sq_s8), .b(p6), .p(sqp6_s10));
	psc_mul64 u_sqp3 (.clk, .en, .a(sq_s8), .b(p3), .p(sqp3_s10));

	psc_delay #(.W(64), .N(2)) u_dly_v1p5 (.clk, .en, .d(v1p5_s8), .q(v1p5_s10));
	psc_delay #(.W(64), .N(2)) u_dly_v1p2 (.clk, .en, .d(v1p2_s8), .q(v1p2_s10));

	always_ff @(posedge clk) begin
		if (en) begin
			v2_s11  <= sqp6_s10 + (v1p5_s10 << 17) + (p4 << 35);
			v1b_s11 <= 64'($signed(sqp3_s10) >>> 8) + (v1p2_s10 << 12);
			y_s12   <= 64'h0000_8000_0000_0000 + v1b_s11;
		end
	end

	psc_delay #(.W(64), .N(3)) u_dly_v2 (.clk, .en, .d(v2_s11), .q(v2_s14));
	psc_delay #(.W(20), .N(14)) u_dly_adcp (.clk, .en, .d(raw_pressure), .q(adcp_s14));
	psc_mul64 u_yp1 (.clk, .en, .a(y_s12), .b(p1), .p(z_s14));

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s15 <= $signed(z_s14) >>> 33;
			pp_s15 <= ((64'd1048576 - {44'h0, adcp_s14}) << 31) - v2_s14;
		end
	end

	psc_mul64 u_nm (.clk, .en, .a(pp_s15), .b(64'd3125), .p(nm_s17));
	psc_delay #(.W(64), .N(2)) u_dly_dv (.clk, .en, .d(dv_s15), .q(dv_s17));

	// Division and the final correction.
	localparam int S_QUO = 17 + DIV_LAT;

	logic [63:0] p_s83, qv, qq_s85, p8p_s85, p8p_s87, qqp9_s87, p_s87, sum_s88, pfin;
	logic        zero_s88;
	temp_res_t   tres_s6, tres_s89;
	logic [31:0] pres_s89;
	logic        pvalid_s89;

	psc_div u_div (.clk, .en, .num(nm_s17), .den(dv_s17), .quo(p_s83));
	psc_delay #(.W(1), .N(N_STAGE - 1 - 17)) u_dly_zero (
		.clk, .en, .d(dv_s17 == 64'd0), .q(zero_s88));

	assign qv = $signed(p_s83) >>> 13;

	psc_mul64 u_qq  (.clk, .en, .a(qv), .b(qv), .p(qq_s85));
	psc_mul64 u_p8p (.clk, .en, .a(p8), .b(p_s83), .p(p8p_s85));
	psc_mul64 u_p9  (.clk, .en, .a(qq_s85), .b(p9), .p(qqp9_s87));
	psc_delay #(.W(64), .N(2)) u_dly_p8p (.clk, .en, .d(p8p_s85), .q(p8p_s87));
	psc_delay #(.W(64), .N(N_STAGE - 2 - S_QUO)) u_dly_p (.clk, .en, .d(p_s83), .q(p_s87));

	assign pfin = 64'($signed(sum_s88) >>> 8) + (p7 << 4);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s88    <= p_s87 + 64'($signed(qqp9_s87) >>> 25) + 64'($signed(p8p_s87) >>> 19);
			pres_s89   <= zero_s88 ? 32'h0 : pfin[31:0];
			pvalid_s89 <= !zero_s88;
		end
	end

	assign tres_s6.tsat  = tsat_s6;
	assign tres_s6.tfine = tfine_s6;

	psc_delay #(.W($bits(temp_res_t)), .N(N_STAGE - 6)) u_dly_temp (
		.clk, .en, .d(tres_s6), .q(tres_s89));

	assign out_valid         = vld_q[N_STAGE];
	assign temperature_centi = tres_s89.tsat;
	assign fine_temperature  = tres_s89.tfine;
	assign pressure_q24_8    = pres_s89;
	assign pressure_valid    = pvalid_s89;

endmodule
